>>> hdl/cif_pkg.sv
// ----------------------------------------------------------------------------
// cif_pkg
// Shared types, register codes and helpers of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cif_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 12;
    localparam int MODE_BITS     = 3;
    localparam int THR_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [FW_BITS-1:0]   FW_RESET   = 11'd640;
    localparam logic [FH_BITS-1:0]   FH_RESET   = 12'd480;
    localparam logic [MODE_BITS-1:0] MODE_RESET = 3'd0;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 11'd0;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THRESHOLD = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_BOX     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_GAUSS   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SHARPEN = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_EMBOSS  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_SOBEL   = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // floor(s/9) == (s*3641)>>15 for every box sum up to 9*255
    localparam int BOX_RECIP   = 3641;
    localparam int BOX_SHIFT   = 15;
    localparam int EMBOSS_BIAS = 128;

    localparam int SQ_BITS   = 21;
    localparam int ROOT_BITS = 11;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    typedef struct packed {
        logic       command;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } cif_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_last;
    } cif_out_t;

    typedef struct packed {
        logic calc1;
        logic calc2;
    } kern_ctl_t;

    function automatic logic [7:0] chan(pix_t p, logic [1:0] c);
        logic [7:0] v;
        case (c)
            2'd0:    v = p.red;
            2'd1:    v = p.green;
            2'd2:    v = p.blue;
            default: v = p.alpha;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] clamp8(logic signed [12:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 13'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/cif_line_store.sv
// ----------------------------------------------------------------------------
// cif_line_store
// Two row buffers (middle and top line) with registered reads.
// ----------------------------------------------------------------------------
module cif_line_store
    import cif_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_mid,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_top,
    output pix_t                         rd_mid,
    output pix_t                         rd_top,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  pix_t                         wr_mid,
    input  pix_t                         wr_top
);

    pix_t mem_mid [MAX_WIDTH];
    pix_t mem_top [MAX_WIDTH];
    pix_t rd_mid_reg;
    pix_t rd_top_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_mid[wr_addr] <= wr_mid;
            mem_top[wr_addr] <= wr_top;
        end
        if (rd_en)
        begin
            rd_mid_reg <= mem_mid[rd_addr_mid];
            rd_top_reg <= mem_top[rd_addr_top];
        end
    end

    assign rd_mid = rd_mid_reg;
    assign rd_top = rd_top_reg;

endmodule

>>> hdl/cif_kernel.sv
// ----------------------------------------------------------------------------
// cif_kernel
// Two-stage kernel arithmetic: window sums, then divide/clamp and squares.
// ----------------------------------------------------------------------------
module cif_kernel
    import cif_pkg::*;
(
    input  logic                 clk,
    input  kern_ctl_t            ctl,
    input  pix_t [8:0]           win,
    input  logic [MODE_BITS-1:0] mode,
    output logic [2:0][7:0]      filt,
    output logic [SQ_BITS-1:0]   sq_sum
);

    logic        [2:0][11:0] box_s1;
    logic        [2:0][11:0] gau_s1;
    logic signed [2:0][12:0] shp_s1;
    logic signed [2:0][12:0] emb_s1;
    logic signed [10:0]      h_s1;
    logic signed [10:0]      v_s1;

    logic        [2:0][11:0] box_reg;
    logic        [2:0][11:0] gau_reg;
    logic signed [2:0][12:0] shp_reg;
    logic signed [2:0][12:0] emb_reg;
    logic signed [10:0]      h_reg;
    logic signed [10:0]      v_reg;

    logic [2:0][7:0] filt_s2;
    logic [19:0]     hh_s2;
    logic [19:0]     vv_s2;
    logic [2:0][7:0] filt_reg;
    logic [19:0]     hh_reg;
    logic [19:0]     vv_reg;

    // stage 1: neighborhood sums per color, Sobel gradients from red
    always_comb
    begin
        logic signed [12:0] p [9];
        logic signed [12:0] r [9];
        for (int i = 0; i < 9; i++)
        begin
            r[i] = $signed({5'b0, win[i].red});
        end
        for (int c = 0; c < 3; c++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p[i] = $signed({5'b0, chan(win[i], 2'(c))});
            end
            box_s1[c] = 12'(p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8]);
            gau_s1[c] = 12'(p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
                            + p[6] + 2 * p[7] + p[8]);
            shp_s1[c] = 13'(5 * p[4] - p[1] - p[3] - p[5] - p[7]);
            emb_s1[c] = 13'(-2 * p[0] - p[1] - p[3] + p[4] + p[5] + p[7] + 2 * p[8]
                            + EMBOSS_BIAS);
        end
        h_s1 = 11'((r[0] + 2 * r[3] + r[6]) - (r[2] + 2 * r[5] + r[8]));
        v_s1 = 11'((r[6] + 2 * r[7] + r[8]) - (r[0] + 2 * r[1] + r[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc1)
        begin
            box_reg <= box_s1;
            gau_reg <= gau_s1;
            shp_reg <= shp_s1;
            emb_reg <= emb_s1;
            h_reg   <= h_s1;
            v_reg   <= v_s1;
        end
    end

    // stage 2: reciprocal divide, clamp, and Sobel squares
    always_comb
    begin
        logic [23:0]        prod;
        logic signed [21:0] hh_full;
        logic signed [21:0] vv_full;
        for (int c = 0; c < 3; c++)
        begin
            prod = 24'(box_reg[c]) * 24'(BOX_RECIP);
            case (mode)
                MODE_BOX:     filt_s2[c] = prod[BOX_SHIFT +: 8];
                MODE_GAUSS:   filt_s2[c] = gau_reg[c][11:4];
                MODE_SHARPEN: filt_s2[c] = clamp8(shp_reg[c]);
                MODE_EMBOSS:  filt_s2[c] = clamp8(emb_reg[c]);
                default:      filt_s2[c] = 8'd0;
            endcase
        end
        hh_full = h_reg * h_reg;
        vv_full = v_reg * v_reg;
        hh_s2   = hh_full[19:0];
        vv_s2   = vv_full[19:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc2)
        begin
            filt_reg <= filt_s2;
            hh_reg   <= hh_s2;
            vv_reg   <= vv_s2;
        end
    end

    assign filt   = filt_reg;
    assign sq_sum = SQ_BITS'(hh_reg) + SQ_BITS'(vv_reg);

endmodule

>>> hdl/cif_isqrt.sv
// ----------------------------------------------------------------------------
// cif_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cif_isqrt
    import cif_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQ_BITS-1:0]   radicand,
    output logic                 busy,
    output logic [ROOT_BITS-1:0] root
);

    localparam int XB = SQ_BITS + 1;

    logic          busy_reg;
    logic [XB-1:0] n_reg;
    logic [XB-1:0] res_reg;
    logic [XB-1:0] bit_reg;
    logic [XB-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= XB'(radicand);
            res_reg <= '0;
            bit_reg <= XB'(1) << (SQ_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_BITS-1:0];

endmodule

>>> hdl/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// Streaming 3x3 RGBA filter: line store, window, kernel and magnitude unit.
// ----------------------------------------------------------------------------
// Flow: a pixel that emits nothing passes S_MEM only; a filtered pixel passes
// S_MEM, S_CALC1..3, S_SQRT (Sobel interior only) and S_EMIT; a drain S_MEM, S_EMIT.
// One item is in work at a time, set by the line store read/write-back cycle
// and the 11-step square root loop; the output register frees the far side.
// Reset: all control state and config registers reset asynchronously, no
// clearing pass; line store contents are undefined until written.
// ----------------------------------------------------------------------------
module conv3x3_image_filter
    import cif_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cif_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cif_out_t                 out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int AW = PW + 1;
    localparam int YW = FH_BITS + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MEM   = 3'd1;
    localparam logic [2:0] S_CALC1 = 3'd2;
    localparam logic [2:0] S_CALC2 = 3'd3;
    localparam logic [2:0] S_CALC3 = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [FW_BITS-1:0]   fw_reg;
    logic [FH_BITS-1:0]   fh_reg;
    logic [MODE_BITS-1:0] mode_reg;
    logic [THR_BITS-1:0]  thr_reg;

    logic [CW-1:0]      col_reg;
    logic [FH_BITS-1:0] row_reg;
    logic [PW-1:0]      pending_reg;
    logic [CW-1:0]      ox_reg;
    logic [FH_BITS-1:0] oy_reg;
    pix_t [8:0]         win_reg;
    logic               out_valid_reg;

    cif_in_t  in_reg;
    pix_t     res_pix_reg;
    logic     sel_top_reg;
    cif_out_t out_data_reg;

    logic [WW-1:0]      eff_w;
    logic [FH_BITS-1:0] eff_h;
    logic               accept;
    logic               out_free;
    logic               emit_now;
    logic               interior;
    logic               last_pos;
    logic               geo_write;

    logic [CW-1:0] cn;
    logic [PW-1:0] k;
    logic          k_lt_w;
    logic [CW-1:0] drain_addr;
    logic [CW-1:0] rd_addr_mid;
    logic [CW-1:0] rd_addr_top;

    pix_t pix_in;
    pix_t rd_mid;
    pix_t rd_top;

    kern_ctl_t             kctl;
    logic [2:0][7:0]       filt;
    logic [SQ_BITS-1:0]    sq_sum;
    logic                  sqrt_busy;
    logic [ROOT_BITS-1:0]  root;
    logic [ROOT_BITS-1:0]  mag_thr;
    logic [7:0]            mag8;
    cif_out_t              result;

    // effective geometry
    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(fw_reg);
        end
        eff_h = (fh_reg == '0) ? FH_BITS'(1) : fh_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_now  = pending_reg > PW'(eff_w);
    assign geo_write = cfg_valid && (cfg_index == REG_FRAME_WIDTH
                                     || cfg_index == REG_FRAME_HEIGHT);

    assign interior = (ox_reg != '0) && (AW'(ox_reg) + AW'(1) < AW'(eff_w))
                      && (oy_reg != '0) && (YW'(oy_reg) + YW'(1) < YW'(eff_h));
    assign last_pos = (AW'(ox_reg) + AW'(1) == AW'(eff_w))
                      && (YW'(oy_reg) + YW'(1) == YW'(eff_h));

    // drain reads the oldest pending pixel: k pixels back from the newest
    always_comb
    begin
        cn     = (col_reg == '0) ? CW'(eff_w - 1'b1) : col_reg - 1'b1;
        k      = pending_reg - 1'b1;
        k_lt_w = k < PW'(eff_w);
        if (AW'(cn) >= AW'(k))
        begin
            drain_addr = CW'(AW'(cn) - AW'(k));
        end
        else
        begin
            drain_addr = CW'(AW'(cn) + AW'(eff_w) - AW'(k));
        end
        if (in_data.command == CMD_PIXEL)
        begin
            rd_addr_mid = col_reg;
            rd_addr_top = col_reg;
        end
        else
        begin
            rd_addr_mid = drain_addr;
            rd_addr_top = cn;
        end
    end

    assign pix_in = '{alpha: in_reg.in_alpha, blue: in_reg.in_blue,
                      green: in_reg.in_green, red: in_reg.in_red};

    cif_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr_mid (rd_addr_mid),
        .rd_addr_top (rd_addr_top),
        .rd_mid      (rd_mid),
        .rd_top      (rd_top),
        .wr_en       (state_reg == S_MEM && in_reg.command == CMD_PIXEL),
        .wr_addr     (col_reg),
        .wr_mid      (pix_in),
        .wr_top      (rd_mid)
    );

    assign kctl.calc1 = (state_reg == S_CALC1);
    assign kctl.calc2 = (state_reg == S_CALC2);

    cif_kernel u_kernel (
        .clk    (clk),
        .ctl    (kctl),
        .win    (win_reg),
        .mode   (mode_reg),
        .filt   (filt),
        .sq_sum (sq_sum)
    );

    cif_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_CALC3 && mode_reg == MODE_SOBEL && interior),
        .radicand (sq_sum),
        .busy     (sqrt_busy),
        .root     (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == CMD_DRAIN && pending_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MEM;
                    end
                end
            end
            S_MEM:
            begin
                if (in_reg.command == CMD_DRAIN)
                begin
                    state_next = S_EMIT;
                end
                else if (emit_now)
                begin
                    state_next = S_CALC1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CALC1: state_next = S_CALC2;
            S_CALC2: state_next = S_CALC3;
            S_CALC3:
            begin
                if (mode_reg == MODE_SOBEL && interior)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SQRT:
            begin
                if (!sqrt_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result assembly
    always_comb
    begin
        mag_thr = (root < thr_reg) ? '0 : root;
        mag8    = (mag_thr > ROOT_BITS'(255)) ? 8'hFF : mag_thr[7:0];
        result  = '0;
        if (in_reg.command == CMD_DRAIN)
        begin
            result.out_red   = res_pix_reg.red;
            result.out_green = res_pix_reg.green;
            result.out_blue  = res_pix_reg.blue;
            result.out_alpha = res_pix_reg.alpha;
        end
        else
        begin
            result.out_alpha = win_reg[4].alpha;
            if (!interior || mode_reg > MODE_SOBEL)
            begin
                result.out_red   = win_reg[4].red;
                result.out_green = win_reg[4].green;
                result.out_blue  = win_reg[4].blue;
            end
            else if (mode_reg == MODE_SOBEL)
            begin
                result.out_red   = mag8;
                result.out_green = mag8;
                result.out_blue  = mag8;
            end
            else
            begin
                result.out_red   = filt[0];
                result.out_green = filt[1];
                result.out_blue  = filt[2];
            end
        end
        result.frame_last = last_pos;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= FW_RESET;
            fh_reg        <= FH_RESET;
            mode_reg      <= MODE_RESET;
            thr_reg       <= THR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            pending_reg   <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_MEM)
            begin
                if (in_reg.command == CMD_DRAIN)
                begin
                    pending_reg <= pending_reg - 1'b1;
                end
                else
                begin
                    // shift the window left, new column enters on the right
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r * 3]     <= win_reg[r * 3 + 1];
                        win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
                    end
                    win_reg[2] <= rd_top;
                    win_reg[5] <= rd_mid;
                    win_reg[8] <= pix_in;
                    if (AW'(col_reg) + AW'(1) >= AW'(eff_w))
                    begin
                        col_reg <= '0;
                        if (YW'(row_reg) + YW'(1) >= YW'(eff_h))
                        begin
                            row_reg <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                    if (!emit_now)
                    begin
                        pending_reg <= pending_reg + 1'b1;
                    end
                end
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                // advance the oldest pending position in raster order
                if (last_pos || AW'(ox_reg) + AW'(1) == AW'(eff_w))
                begin
                    ox_reg <= '0;
                    if (YW'(oy_reg) + YW'(1) == YW'(eff_h))
                    begin
                        oy_reg <= '0;
                    end
                    else
                    begin
                        oy_reg <= oy_reg + 1'b1;
                    end
                end
                else
                begin
                    ox_reg <= ox_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:    fw_reg   <= cfg_data[FW_BITS-1:0];
                    REG_FRAME_HEIGHT:   fh_reg   <= cfg_data[FH_BITS-1:0];
                    REG_FILTER_MODE:    mode_reg <= cfg_data[MODE_BITS-1:0];
                    REG_EDGE_THRESHOLD: thr_reg  <= cfg_data[THR_BITS-1:0];
                    default:            ;
                endcase
            end

            // geometry change restarts the stream
            if (geo_write)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                pending_reg <= '0;
                ox_reg      <= '0;
                oy_reg      <= '0;
                win_reg     <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg      <= in_data;
            sel_top_reg <= !k_lt_w;
        end
        if (state_reg == S_MEM)
        begin
            res_pix_reg <= sel_top_reg ? rd_top : rd_mid;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
